/* design/ssa_pkg.sv */
// Shared types, constants and helper functions for the scanline span accumulator.
// Depends on nothing; every other design file but ssa_if imports it.
package ssa_pkg;

    localparam int ROW_COUNT_DEF = 1024;
    localparam int FRAC_BITS_DEF = 4;
    localparam int QUEUE_DEPTH   = 2;
    // Width of band coordinates (row scaled by the fraction bits, signed).
    localparam int CW            = 24;

    localparam logic [11:0] X_EMPTY = 12'd2048;
    localparam logic [10:0] Y_EMPTY = 11'd1024;

    typedef enum logic [1:0] {
        FN_EDGE  = 2'd0,
        FN_BOX   = 2'd1,
        FN_READ  = 2'd2,
        FN_CLEAR = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        CFG_MIN_X = 2'd0,
        CFG_MAX_X = 2'd1,
        CFG_MIN_Y = 2'd2,
        CFG_MAX_Y = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [10:0] min_x;
        logic [10:0] max_x;
        logic [9:0]  min_y;
        logic [9:0]  max_y;
    } t_cfg;

    typedef struct packed {
        t_func              op;
        logic signed [15:0] lx;
        logic signed [15:0] ly;
        logic signed [15:0] hx;
        logic signed [15:0] hy;
        logic [9:0]         rlo;
        logic [9:0]         rhi;
        logic [10:0]        xlo;
        logic [10:0]        xhi;
        logic [9:0]         rd_row;
        logic               rd_ok;
    } t_cmd;

    typedef struct packed {
        logic                 start;
        logic signed [CW-1:0] b;
        logic signed [15:0]   lx;
        logic signed [15:0]   ly;
        logic signed [16:0]   dx;
        logic [16:0]          dy;
    } t_ip_req;

    typedef enum logic [1:0] {
        IP_IDLE,
        IP_MUL,
        IP_DIV,
        IP_FIN
    } t_ip_state;

    typedef enum logic [3:0] {
        BE_IDLE,
        BE_CLEAR,
        BE_EROW,
        BE_ETOP,
        BE_EBOT,
        BE_EUPD,
        BE_BOX,
        BE_RD,
        BE_RDW,
        BE_DONE
    } t_be_state;

    // Raise to the lower limit first, then lower to the upper limit.
    function automatic logic [10:0] clamp_col(input logic signed [15:0] v,
                                              input logic [10:0] lo,
                                              input logic [10:0] hi);
        logic signed [16:0] t;
        t = {v[15], v};
        if (t < $signed({6'b0, lo})) t = $signed({6'b0, lo});
        if (t > $signed({6'b0, hi})) t = $signed({6'b0, hi});
        return t[10:0];
    endfunction

    function automatic logic [9:0] clamp_row(input logic signed [15:0] v,
                                             input logic [9:0] lo,
                                             input logic [9:0] hi);
        logic signed [16:0] t;
        t = {v[15], v};
        if (t < $signed({7'b0, lo})) t = $signed({7'b0, lo});
        if (t > $signed({7'b0, hi})) t = $signed({7'b0, hi});
        return t[9:0];
    endfunction

endpackage

/* design/ssa_if.sv */
// Valid/ready channel interfaces for the scanline span accumulator.
// Holds the input item channel and the result item channel; no dependencies.
interface ssa_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         func;
    logic signed [15:0] x0;
    logic signed [15:0] y0;
    logic signed [15:0] x1;
    logic signed [15:0] y1;
    logic signed [15:0] x2;
    logic signed [15:0] y2;
    logic [9:0]         row;

    modport source (output valid, func, x0, y0, x1, y1, x2, y2, row, input ready);
    modport sink   (input valid, func, x0, y0, x1, y1, x2, y2, row, output ready);
endinterface

interface ssa_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] span_min_x;
    logic [10:0] span_max_x;
    logic [10:0] extent_min_y;
    logic [9:0]  extent_max_y;

    modport source (output valid, span_min_x, span_max_x, extent_min_y, extent_max_y,
                    input ready);
    modport sink   (input valid, span_min_x, span_max_x, extent_min_y, extent_max_y,
                    output ready);
endinterface

/* design/ssa_fifo.sv */
// Short command queue between the front and back parts.
// Depends on ssa_pkg for the command type.
module ssa_fifo #(
    parameter int DEPTH = ssa_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ssa_pkg::t_cmd i_data,
    output logic          o_ready,
    input  logic          i_pop,
    output logic          o_valid,
    output ssa_pkg::t_cmd o_data
);
    import ssa_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [NW-1:0] r_cnt;
    logic          w_do_push;
    logic          w_do_pop;

    assign o_ready   = (r_cnt != NW'(DEPTH));
    assign o_valid   = (r_cnt != '0);
    assign o_data    = r_mem[r_rp];
    assign w_do_push = i_push && o_ready;
    assign w_do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_do_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (w_do_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
            end
            if (w_do_push && !w_do_pop) begin
                r_cnt <= r_cnt + NW'(1);
            end else if (w_do_pop && !w_do_push) begin
                r_cnt <= r_cnt - NW'(1);
            end
        end
    end

endmodule

/* design/ssa_interp.sv */
// Edge interpolation unit: x = lx + floor((b - ly) * dx / dy), one quotient bit per cycle.
// Depends on ssa_pkg for the request type and state enum.
module ssa_interp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ssa_pkg::t_ip_req   i_req,
    output logic               o_done,
    output logic signed [15:0] o_px
);
    import ssa_pkg::*;

    localparam int NW = 34;

    t_ip_state          r_state;
    t_ip_state          n_state;
    logic [5:0]         r_cnt;
    logic [16:0]        r_dif;
    logic signed [16:0] r_dx;
    logic [16:0]        r_dy;
    logic signed [15:0] r_lx;
    logic [NW-1:0]      r_num;
    logic [16:0]        r_rem;
    logic [17:0]        r_quo;
    logic               r_neg;

    logic                 w_take;
    logic signed [CW-1:0] w_ly_ext;
    logic signed [CW-1:0] w_dif;
    logic signed [34:0]   w_prod;
    logic [NW-1:0]        w_mag;
    logic [17:0]          w_sh;
    logic                 w_qbit;
    logic [17:0]          w_sub;
    logic signed [19:0]   w_qm;
    logic signed [19:0]   w_q;
    logic signed [19:0]   w_px;

    assign w_take   = i_req.start && (r_state == IP_IDLE || r_state == IP_FIN);
    assign w_ly_ext = $signed({{(CW - 16){i_req.ly[15]}}, i_req.ly});
    assign w_dif    = i_req.b - w_ly_ext;
    assign w_prod   = $signed({1'b0, r_dif}) * r_dx;
    assign w_mag    = w_prod[34] ? NW'(-w_prod) : w_prod[NW-1:0];
    assign w_sh     = {r_rem, r_num[NW-1]};
    assign w_sub    = w_sh - {1'b0, r_dy};
    assign w_qbit   = (w_sh >= {1'b0, r_dy});
    assign w_qm     = $signed({2'b0, r_quo});
    assign w_q      = r_neg ? (-w_qm - 20'(r_rem != '0)) : w_qm;
    assign w_px     = $signed({{4{r_lx[15]}}, r_lx}) + w_q;

    always_comb begin
        n_state = r_state;
        case (r_state)
            IP_IDLE: if (w_take) n_state = IP_MUL;
            IP_MUL:  n_state = IP_DIV;
            IP_DIV:  if (r_cnt == 6'(NW - 1)) n_state = IP_FIN;
            IP_FIN:  n_state = w_take ? IP_MUL : IP_IDLE;
            default: n_state = IP_IDLE;
        endcase
    end

    always_comb begin
        o_done = (r_state == IP_FIN);
        o_px   = w_px[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= IP_IDLE;
        end else begin
            r_state <= n_state;
        end
        if (w_take) begin
            r_dif <= w_dif[16:0];
            r_dx  <= i_req.dx;
            r_dy  <= i_req.dy;
            r_lx  <= i_req.lx;
        end
        if (r_state == IP_MUL) begin
            r_neg <= w_prod[34];
            r_num <= w_mag;
            r_rem <= '0;
            r_quo <= '0;
            r_cnt <= '0;
        end
        if (r_state == IP_DIV) begin
            r_num <= {r_num[NW-2:0], 1'b0};
            r_rem <= w_qbit ? w_sub[16:0] : w_sh[16:0];
            r_quo <= {r_quo[16:0], w_qbit};
            r_cnt <= r_cnt + 6'd1;
        end
    end

endmodule

/* design/ssa_front.sv */
// Front part: accepts input items, sorts edge endpoints, floors and clamps rows and columns.
// Depends on ssa_pkg and the ssa_in_if interface.
module ssa_front #(
    parameter int ROW_COUNT = ssa_pkg::ROW_COUNT_DEF,
    parameter int FRAC_BITS = ssa_pkg::FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ssa_in_if.sink        s_in,
    input  ssa_pkg::t_cfg i_cfg,
    input  logic          i_hold,
    output logic          o_push,
    output ssa_pkg::t_cmd o_cmd,
    input  logic          i_q_ready
);
    import ssa_pkg::*;

    logic               r_vld;
    t_cmd               r_cmd;
    t_cmd               w_cmd;
    logic               w_acc;
    logic [9:0]         w_row_hi;
    logic signed [15:0] w_lx, w_ly, w_hx, w_hy;
    logic signed [15:0] w_bxl, w_bxh, w_byl, w_byh;
    logic signed [15:0] w_rlo_v, w_rhi_v;

    function automatic logic signed [15:0] min3(input logic signed [15:0] a, b, c);
        logic signed [15:0] m;
        m = (a < b) ? a : b;
        return (c < m) ? c : m;
    endfunction

    function automatic logic signed [15:0] max3(input logic signed [15:0] a, b, c);
        logic signed [15:0] m;
        m = (a > b) ? a : b;
        return (c > m) ? c : m;
    endfunction

    always_comb begin
        w_row_hi = ({3'b0, i_cfg.max_y} > 13'(ROW_COUNT - 1)) ? 10'(ROW_COUNT - 1)
                                                               : i_cfg.max_y;
        if (s_in.y0 <= s_in.y1) begin
            w_lx = s_in.x0; w_ly = s_in.y0; w_hx = s_in.x1; w_hy = s_in.y1;
        end else begin
            w_lx = s_in.x1; w_ly = s_in.y1; w_hx = s_in.x0; w_hy = s_in.y0;
        end
        w_bxl = min3(s_in.x0, s_in.x1, s_in.x2);
        w_bxh = max3(s_in.x0, s_in.x1, s_in.x2);
        w_byl = min3(s_in.y0, s_in.y1, s_in.y2);
        w_byh = max3(s_in.y0, s_in.y1, s_in.y2);

        w_cmd.op = t_func'(s_in.func);
        if (w_cmd.op == FN_BOX) begin
            w_rlo_v = w_byl >>> FRAC_BITS;
            w_rhi_v = w_byh >>> FRAC_BITS;
        end else begin
            w_rlo_v = w_ly >>> FRAC_BITS;
            w_rhi_v = w_hy >>> FRAC_BITS;
        end
        w_cmd.lx     = w_lx;
        w_cmd.ly     = w_ly;
        w_cmd.hx     = w_hx;
        w_cmd.hy     = w_hy;
        w_cmd.rlo    = clamp_row(w_rlo_v, i_cfg.min_y, w_row_hi);
        w_cmd.rhi    = clamp_row(w_rhi_v, i_cfg.min_y, w_row_hi);
        w_cmd.xlo    = clamp_col(w_bxl >>> FRAC_BITS, i_cfg.min_x, i_cfg.max_x);
        w_cmd.xhi    = clamp_col(w_bxh >>> FRAC_BITS, i_cfg.min_x, i_cfg.max_x);
        w_cmd.rd_row = s_in.row;
        w_cmd.rd_ok  = ({3'b0, s_in.row} < 13'(ROW_COUNT));
    end

    assign s_in.ready = !i_hold && (!r_vld || i_q_ready);
    assign w_acc      = s_in.valid && s_in.ready;
    assign o_push     = r_vld;
    assign o_cmd      = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_acc) begin
            r_vld <= 1'b1;
        end else if (i_q_ready) begin
            r_vld <= 1'b0;
        end
        if (w_acc) begin
            r_cmd <= w_cmd;
        end
    end

endmodule

/* design/ssa_back.sv */
// Back part: owns the span table and row extent and carries out queued commands.
// Depends on ssa_pkg, ssa_out_if and ssa_interp.
module ssa_back #(
    parameter int ROW_COUNT = ssa_pkg::ROW_COUNT_DEF,
    parameter int FRAC_BITS = ssa_pkg::FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  ssa_pkg::t_cmd i_q_cmd,
    output logic          o_pop,
    input  ssa_pkg::t_cfg i_cfg,
    output logic          o_init,
    ssa_out_if.source     m_out
);
    import ssa_pkg::*;

    localparam int AW = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;

    t_be_state     r_state;
    t_be_state     n_state;
    t_cmd          r_cmd;
    logic [9:0]    r_row;
    logic [AW-1:0] r_clr;
    logic          r_init;
    logic [10:0]   r_ext_min;
    logic [9:0]    r_ext_max;
    logic [11:0]   r_smin;
    logic [10:0]   r_smax;
    logic signed [15:0] r_px0;
    logic signed [15:0] r_px1;
    logic          r_need_bot;
    logic signed [CW-1:0] r_bot;
    logic [22:0]   r_mem [ROW_COUNT];
    logic [22:0]   r_mem_q;
    logic          r_o_vld;
    logic [11:0]   r_o_smin;
    logic [10:0]   r_o_smax;
    logic [10:0]   r_o_emin;
    logic [9:0]    r_o_emax;

    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [22:0]   w_wdata;
    logic          w_re;
    logic [AW-1:0] w_raddr;
    logic          w_out_load;
    logic [11:0]   w_row12;
    logic [11:0]   w_rd12;
    t_ip_req       w_ip_req;
    logic          w_ip_done;
    logic signed [15:0] w_ip_px;

    logic signed [CW-1:0] w_top, w_bot, w_ly, w_hy, w_py0;
    logic          w_above, w_below, w_need_top, w_need_bot;
    logic signed [15:0] w_pmin, w_pmax;
    logic [10:0]   w_cmn, w_cmx;
    logic [11:0]   w_new_min;
    logic [10:0]   w_new_max;

    ssa_interp u_interp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_ip_req),
        .o_done  (w_ip_done),
        .o_px    (w_ip_px)
    );

    assign w_row12 = {2'b00, r_row};
    assign w_rd12  = {2'b00, r_cmd.rd_row};
    assign o_init  = r_init;

    // Band edges of the current row and the clipping decisions for it.
    always_comb begin
        w_top      = $signed({{(CW - 10){1'b0}}, r_row}) <<< FRAC_BITS;
        w_bot      = $signed({{(CW - 10){1'b0}}, r_row} + CW'(1)) <<< FRAC_BITS;
        w_ly       = $signed({{(CW - 16){r_cmd.ly[15]}}, r_cmd.ly});
        w_hy       = $signed({{(CW - 16){r_cmd.hy[15]}}, r_cmd.hy});
        w_above    = (w_hy < w_top);
        w_below    = !w_above && (w_bot < w_ly);
        w_need_top = !w_above && !w_below && (w_ly < w_top) && (w_top < w_hy);
        w_py0      = w_need_top ? w_top : w_ly;
        w_need_bot = !w_above && !w_below && (w_py0 < w_bot) && (w_bot < w_hy);

        w_pmin    = (r_px0 < r_px1) ? r_px0 : r_px1;
        w_pmax    = (r_px0 < r_px1) ? r_px1 : r_px0;
        w_cmn     = clamp_col(w_pmin >>> FRAC_BITS, i_cfg.min_x, i_cfg.max_x);
        w_cmx     = clamp_col(w_pmax >>> FRAC_BITS, i_cfg.min_x, i_cfg.max_x);
        w_new_min = ({1'b0, w_cmn} < r_mem_q[22:11]) ? {1'b0, w_cmn} : r_mem_q[22:11];
        w_new_max = (w_cmx > r_mem_q[10:0]) ? w_cmx : r_mem_q[10:0];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            BE_IDLE: begin
                if (i_q_valid) begin
                    case (i_q_cmd.op)
                        FN_EDGE: n_state = BE_EROW;
                        FN_BOX:  n_state = BE_BOX;
                        FN_READ: n_state = BE_RD;
                        default: n_state = BE_CLEAR;
                    endcase
                end
            end
            BE_CLEAR: begin
                if (r_clr == AW'(ROW_COUNT - 1)) n_state = r_init ? BE_IDLE : BE_DONE;
            end
            BE_EROW: begin
                if (w_need_top) n_state = BE_ETOP;
                else if (w_need_bot) n_state = BE_EBOT;
                else n_state = BE_EUPD;
            end
            BE_ETOP: begin
                if (w_ip_done) n_state = r_need_bot ? BE_EBOT : BE_EUPD;
            end
            BE_EBOT: begin
                if (w_ip_done) n_state = BE_EUPD;
            end
            BE_EUPD: n_state = (r_row == r_cmd.rhi) ? BE_DONE : BE_EROW;
            BE_BOX:  n_state = (r_row == r_cmd.rhi) ? BE_DONE : BE_BOX;
            BE_RD:   n_state = r_cmd.rd_ok ? BE_RDW : BE_DONE;
            BE_RDW:  n_state = BE_DONE;
            BE_DONE: if (!r_o_vld || m_out.ready) n_state = BE_IDLE;
            default: n_state = BE_IDLE;
        endcase
    end

    always_comb begin
        o_pop          = (r_state == BE_IDLE) && i_q_valid;
        w_we           = 1'b0;
        w_waddr        = w_row12[AW-1:0];
        w_wdata        = {X_EMPTY, 11'd0};
        w_re           = 1'b0;
        w_raddr        = w_row12[AW-1:0];
        w_out_load     = (r_state == BE_DONE) && (!r_o_vld || m_out.ready);
        w_ip_req.start = 1'b0;
        w_ip_req.b     = r_bot;
        w_ip_req.lx    = r_cmd.lx;
        w_ip_req.ly    = r_cmd.ly;
        w_ip_req.dx    = $signed({r_cmd.hx[15], r_cmd.hx}) - $signed({r_cmd.lx[15], r_cmd.lx});
        w_ip_req.dy    = {r_cmd.hy[15], r_cmd.hy} - {r_cmd.ly[15], r_cmd.ly};
        case (r_state)
            BE_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
            end
            BE_EROW: begin
                w_re           = 1'b1;
                w_ip_req.start = w_need_top || w_need_bot;
                w_ip_req.b     = w_need_top ? w_top : w_bot;
            end
            BE_ETOP: begin
                w_ip_req.start = w_ip_done && r_need_bot;
            end
            BE_EUPD: begin
                w_we    = 1'b1;
                w_wdata = {w_new_min, w_new_max};
            end
            BE_BOX: begin
                w_we    = 1'b1;
                w_wdata = {1'b0, r_cmd.xlo, r_cmd.xhi};
            end
            BE_RD: begin
                w_re    = r_cmd.rd_ok;
                w_raddr = w_rd12[AW-1:0];
            end
            default: begin
            end
        endcase
    end

    // Span table: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_mem_q <= r_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BE_CLEAR;
            r_init    <= 1'b1;
            r_clr     <= '0;
            r_ext_min <= Y_EMPTY;
            r_ext_max <= '0;
            r_o_vld   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == BE_CLEAR) begin
                r_clr <= r_clr + AW'(1);
                if (r_clr == AW'(ROW_COUNT - 1)) r_init <= 1'b0;
            end
            if (o_pop) begin
                r_clr <= '0;
                if (i_q_cmd.op == FN_CLEAR) begin
                    r_ext_min <= Y_EMPTY;
                    r_ext_max <= '0;
                end else if (i_q_cmd.op == FN_EDGE || i_q_cmd.op == FN_BOX) begin
                    if ({1'b0, i_q_cmd.rlo} < r_ext_min) r_ext_min <= {1'b0, i_q_cmd.rlo};
                    if (i_q_cmd.rhi > r_ext_max) r_ext_max <= i_q_cmd.rhi;
                end
            end
            if (w_out_load) begin
                r_o_vld <= 1'b1;
            end else if (m_out.ready) begin
                r_o_vld <= 1'b0;
            end
        end

        if (o_pop) begin
            r_cmd  <= i_q_cmd;
            r_row  <= i_q_cmd.rlo;
            r_smin <= X_EMPTY;
            r_smax <= '0;
        end
        if (r_state == BE_EROW) begin
            r_px0      <= w_above ? r_cmd.hx : r_cmd.lx;
            r_px1      <= w_below ? r_cmd.lx : r_cmd.hx;
            r_need_bot <= w_need_bot;
            r_bot      <= w_bot;
        end
        if (r_state == BE_ETOP && w_ip_done) begin
            r_px0 <= w_ip_px;
        end
        if (r_state == BE_EBOT && w_ip_done) begin
            r_px1 <= w_ip_px;
        end
        if ((r_state == BE_EUPD || r_state == BE_BOX) && r_row != r_cmd.rhi) begin
            r_row <= r_row + 10'd1;
        end
        if (r_state == BE_RDW) begin
            r_smin <= r_mem_q[22:11];
            r_smax <= r_mem_q[10:0];
        end
        if (w_out_load) begin
            r_o_smin <= r_smin;
            r_o_smax <= r_smax;
            r_o_emin <= r_ext_min;
            r_o_emax <= r_ext_max;
        end
    end

    assign m_out.valid        = r_o_vld;
    assign m_out.span_min_x   = r_o_smin;
    assign m_out.span_max_x   = r_o_smax;
    assign m_out.extent_min_y = r_o_emin;
    assign m_out.extent_max_y = r_o_emax;

    a_extent_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ext_min != Y_EMPTY) |-> (r_ext_min <= {1'b0, r_ext_max}))
        else $error("touched row extent is inverted");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BE_EROW) |-> (r_row <= r_cmd.rhi))
        else $error("edge walk passed its last row");

    a_no_pop_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_init |-> !o_pop)
        else $error("command taken during the table clearing pass");

    a_interp_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ip_done |-> (r_state == BE_ETOP || r_state == BE_EBOT))
        else $error("interpolation result arrived with no row waiting for it");

endmodule

/* design/scanline_span_accumulator.sv */
// Top level of the scanline span accumulator: configuration registers, front part,
// command queue and back part. Depends on ssa_pkg, ssa_if, ssa_fifo, ssa_front, ssa_back.
//
// Usage. Items arrive on i_item (valid/ready) and each one produces exactly one result
// item on o_res (valid/ready). func selects add edge, add box, read row or clear table. The clip registers are written
// through i_cfg_we / i_cfg_idx / i_cfg_wdata; the user must write them only while the block is idle,
// which the block itself does not enforce. A write takes effect at the clock edge where i_cfg_we is high.
//
// The front part registers an item and then places it in a two-entry queue, so items keep
// flowing in while the back part works or a result waits. In the back part an edge reads
// each row, interpolates an x for each band-edge crossing that needs one (at most two per
// row) with the bit-serial divider of the interpolation unit, and writes the row back. A
// box writes one row per cycle, a read fetches one row of the table, and a clear sweeps
// the whole table.
//
// Reset. After reset the back part clears the span table one row per cycle, over all ROW_COUNT
// rows; i_item.ready stays low during that pass, while configuration writes are taken.
// When the receiver stalls, the finished result holds in the output register; the back
// part then waits and the queue and front part fill before i_item.ready drops.
module scanline_span_accumulator #(
    parameter int ROW_COUNT = ssa_pkg::ROW_COUNT_DEF,
    parameter int FRAC_BITS = ssa_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [10:0] i_cfg_wdata,
    ssa_in_if.sink      i_item,
    ssa_out_if.source   o_res
);
    import ssa_pkg::*;

    t_cfg r_cfg;
    logic w_push;
    t_cmd w_push_cmd;
    logic w_q_ready;
    logic w_q_valid;
    t_cmd w_q_cmd;
    logic w_pop;
    logic w_init;

    // Clip registers; the upper limit wins when the limits cross.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_x <= 11'd0;
            r_cfg.max_x <= 11'd2047;
            r_cfg.min_y <= 10'd0;
            r_cfg.max_y <= 10'd1023;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_MIN_X: r_cfg.min_x <= i_cfg_wdata;
                CFG_MAX_X: r_cfg.max_x <= i_cfg_wdata;
                CFG_MIN_Y: r_cfg.min_y <= i_cfg_wdata[9:0];
                CFG_MAX_Y: r_cfg.max_y <= i_cfg_wdata[9:0];
                default: begin
                end
            endcase
        end
    end

    ssa_front #(
        .ROW_COUNT (ROW_COUNT),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .s_in      (i_item),
        .i_cfg     (r_cfg),
        .i_hold    (w_init),
        .o_push    (w_push),
        .o_cmd     (w_push_cmd),
        .i_q_ready (w_q_ready)
    );

    ssa_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_cmd),
        .o_ready (w_q_ready),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_cmd)
    );

    ssa_back #(
        .ROW_COUNT (ROW_COUNT),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_cmd   (w_q_cmd),
        .o_pop     (w_pop),
        .i_cfg     (r_cfg),
        .o_init    (w_init),
        .m_out     (o_res)
    );

endmodule
